// ===== design/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

  localparam int unsigned HueW  = 13;
  localparam int unsigned ChanW = 8;
  localparam int unsigned FracW = 10;
  localparam int unsigned ProdW = 18;

  localparam int unsigned SectorSpan = 960;
  localparam logic [HueW-1:0]  HueMax   = 13'd5759;
  localparam logic [ChanW-1:0] ChanMax  = 8'd255;
  localparam logic [ProdW-1:0] FullProd = 18'd244800;

  // Division by 255 for a 16-bit product: multiply by 0x8081, shift right by 23.
  localparam logic [15:0]      RecipP  = 16'h8081;
  localparam int unsigned      PShift  = 23;
  // Division by 244800 = 64 * 3825: shift right by 6, multiply by the
  // rounded-up reciprocal of 3825, shift right by 32.
  localparam int unsigned      QPreShift = 6;
  localparam logic [20:0]      RecipQ    = 21'd1122868;
  localparam int unsigned      QShift    = 32;

  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_e;

  typedef struct packed {
    sector_e          sector;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
    logic [ProdW-1:0] prod_q;
    logic [ProdW-1:0] prod_t;
  } work_t;

endpackage

// ===== design/hsv2rgb_intf.sv =====
interface hsv2rgb_hsv_if;
  logic        valid;
  logic        ready;
  logic [12:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  value;

  modport source (output valid, output hue, output saturation, output value, input ready);
  modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

interface hsv2rgb_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface hsv2rgb_work_if import hsv2rgb_pkg::*;;
  logic  valid;
  logic  ready;
  work_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/hsv2rgb_front.sv =====
module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  hsv2rgb_hsv_if.sink     pix_i,
  hsv2rgb_work_if.source  work_o
);

  logic [HueW-1:0]  hue_c;
  logic [HueW-1:0]  base;
  logic [FracW-1:0] frac;
  sector_e          sector;
  work_t            work_d;
  work_t            work_q;
  logic             valid_q;
  logic             load;

  always_comb begin
    hue_c = (pix_i.hue > HueMax) ? HueMax : pix_i.hue;
    if (hue_c >= HueW'(5 * SectorSpan)) begin
      sector = SEC_MAG_RED;
      base   = HueW'(5 * SectorSpan);
    end else if (hue_c >= HueW'(4 * SectorSpan)) begin
      sector = SEC_BLU_MAG;
      base   = HueW'(4 * SectorSpan);
    end else if (hue_c >= HueW'(3 * SectorSpan)) begin
      sector = SEC_CYN_BLU;
      base   = HueW'(3 * SectorSpan);
    end else if (hue_c >= HueW'(2 * SectorSpan)) begin
      sector = SEC_GRN_CYN;
      base   = HueW'(2 * SectorSpan);
    end else if (hue_c >= HueW'(SectorSpan)) begin
      sector = SEC_YEL_GRN;
      base   = HueW'(SectorSpan);
    end else begin
      sector = SEC_RED_YEL;
      base   = '0;
    end
    frac = FracW'(hue_c - base);

    work_d.sector = sector;
    work_d.sat    = pix_i.saturation;
    work_d.val    = pix_i.value;
    work_d.prod_q = ProdW'(pix_i.saturation) * ProdW'(frac);
    work_d.prod_t = ProdW'(pix_i.saturation) * (ProdW'(SectorSpan) - ProdW'(frac));
  end

  assign load        = !valid_q || work_o.ready;
  assign pix_i.ready = load;
  assign work_o.valid = valid_q;
  assign work_o.data  = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && pix_i.valid) begin
      work_q <= work_d;
    end
  end

endmodule

// ===== design/hsv2rgb_queue.sv =====
module hsv2rgb_queue import hsv2rgb_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  hsv2rgb_work_if.sink   work_i,
  hsv2rgb_work_if.source work_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  work_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q;
  logic [PtrW-1:0] rd_ptr_d;
  logic [CntW-1:0] count_q;
  logic [CntW-1:0] count_d;
  logic            push;
  logic            pop;

  assign work_i.ready = (count_q != CntW'(Depth));
  assign work_o.valid = (count_q != '0);
  assign work_o.data  = mem_q[rd_ptr_q];

  assign push = work_i.valid && work_i.ready;
  assign pop  = work_o.valid && work_o.ready;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= work_i.data;
    end
  end

endmodule

// ===== design/hsv2rgb_back.sv =====
module hsv2rgb_back import hsv2rgb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsv2rgb_work_if.sink  work_i,
  hsv2rgb_rgb_if.source pix_o
);

  localparam int unsigned PW  = 2 * ChanW;
  localparam int unsigned QW  = ChanW + ProdW;
  localparam int unsigned QSW = QW - QPreShift;
  localparam int unsigned MPW = 2 * PW;
  localparam int unsigned MQW = QSW + 21;

  // Stage B: value times the scaled numerators.
  logic             vb_q;
  sector_e          sector_b_q;
  logic [ChanW-1:0] val_b_q;
  logic [PW-1:0]    prod_p_b_q;
  logic [QW-1:0]    prod_q_b_q;
  logic [QW-1:0]    prod_t_b_q;
  logic [ProdW-1:0] num_q;
  logic [ProdW-1:0] num_t;

  // Stage C: divisions by reciprocal multiplication.
  logic             vc_q;
  sector_e          sector_c_q;
  logic [ChanW-1:0] val_c_q;
  logic [ChanW-1:0] chan_p_q;
  logic [ChanW-1:0] chan_q_q;
  logic [ChanW-1:0] chan_t_q;
  logic [MPW-1:0]   mult_p;
  logic [MQW-1:0]   mult_q;
  logic [MQW-1:0]   mult_t;

  // Stage D: output register.
  logic             vd_q;
  logic [ChanW-1:0] red_d;
  logic [ChanW-1:0] green_d;
  logic [ChanW-1:0] blue_d;
  logic [ChanW-1:0] red_q;
  logic [ChanW-1:0] green_q;
  logic [ChanW-1:0] blue_q;

  logic en_b;
  logic en_c;
  logic en_d;

  assign en_d         = !vd_q || pix_o.ready;
  assign en_c         = !vc_q || en_d;
  assign en_b         = !vb_q || en_c;
  assign work_i.ready = en_b;

  assign num_q = FullProd - work_i.data.prod_q;
  assign num_t = FullProd - work_i.data.prod_t;

  assign mult_p = MPW'(prod_p_b_q) * MPW'(RecipP);
  assign mult_q = MQW'(prod_q_b_q[QW-1:QPreShift]) * MQW'(RecipQ);
  assign mult_t = MQW'(prod_t_b_q[QW-1:QPreShift]) * MQW'(RecipQ);

  always_comb begin
    case (sector_c_q)
      SEC_RED_YEL: begin
        red_d = val_c_q;  green_d = chan_t_q; blue_d = chan_p_q;
      end
      SEC_YEL_GRN: begin
        red_d = chan_q_q; green_d = val_c_q;  blue_d = chan_p_q;
      end
      SEC_GRN_CYN: begin
        red_d = chan_p_q; green_d = val_c_q;  blue_d = chan_t_q;
      end
      SEC_CYN_BLU: begin
        red_d = chan_p_q; green_d = chan_q_q; blue_d = val_c_q;
      end
      SEC_BLU_MAG: begin
        red_d = chan_t_q; green_d = chan_p_q; blue_d = val_c_q;
      end
      default: begin
        red_d = val_c_q;  green_d = chan_p_q; blue_d = chan_q_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (en_b) begin
        vb_q <= work_i.valid;
      end
      if (en_c) begin
        vc_q <= vb_q;
      end
      if (en_d) begin
        vd_q <= vc_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b && work_i.valid) begin
      sector_b_q <= work_i.data.sector;
      val_b_q    <= work_i.data.val;
      prod_p_b_q <= PW'(work_i.data.val) * PW'(ChanMax - work_i.data.sat);
      prod_q_b_q <= QW'(work_i.data.val) * QW'(num_q);
      prod_t_b_q <= QW'(work_i.data.val) * QW'(num_t);
    end
    if (en_c && vb_q) begin
      sector_c_q <= sector_b_q;
      val_c_q    <= val_b_q;
      chan_p_q   <= mult_p[PShift +: ChanW];
      chan_q_q   <= mult_q[QShift +: ChanW];
      chan_t_q   <= mult_t[QShift +: ChanW];
    end
    if (en_d && vc_q) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign pix_o.valid = vd_q;
  assign pix_o.red   = red_q;
  assign pix_o.green = green_q;
  assign pix_o.blue  = blue_q;

endmodule

// ===== design/hsv_to_rgb_converter.sv =====
// An accepted input transaction is registered in the front stage, written into the
// queue, then passes the three back stages B, C and D to the output.
// Throughput: one pixel per clock while pix_o is not stalled, set by the fully
// pipelined multipliers.
// Reset clears all valid flags and queue pointers at once; no clearing pass.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hsv2rgb_hsv_if.sink   pix_i,
  hsv2rgb_rgb_if.source pix_o
);

  hsv2rgb_work_if fq_if ();
  hsv2rgb_work_if qb_if ();

  hsv2rgb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .work_o (fq_if)
  );

  hsv2rgb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .work_i (fq_if),
    .work_o (qb_if)
  );

  hsv2rgb_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .work_i (qb_if),
    .pix_o  (pix_o)
  );

`ifndef SYNTH
  // The two saturation products cover one full sector span between them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_if.valid |-> (19'(fq_if.data.prod_q) + 19'(fq_if.data.prod_t))
                    == 19'(fq_if.data.sat) * 19'd960)
    else $error("front products inconsistent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qb_if.valid |-> (19'(qb_if.data.prod_q) + 19'(qb_if.data.prod_t))
                    == 19'(qb_if.data.sat) * 19'd960)
    else $error("queued products inconsistent");

  // A transaction leaving the queue while the back end is free reaches the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (qb_if.valid && qb_if.ready && pix_o.ready) ##1 pix_o.ready ##1 pix_o.ready
      |=> pix_o.valid)
    else $error("transaction lost in back pipeline");
`endif

endmodule
